@@ rtl/hvn_pkg.sv @@
// Shared types and constants for the hashed 2D value noise pipeline.
`timescale 1ns / 1ps

package hvn_pkg;

  // Coordinate format: fraction bits per coordinate, 8 to 24
  localparam int FRAC_BITS = 16;

  // Noise and easing values are Q0.24
  localparam int Q_BITS = 24;

  // Cycles from an accepted request to its result strobe
  localparam int LATENCY = 9;

  typedef logic [31:0]         word_t;
  typedef logic [Q_BITS-1:0]   q24_t;

  // Hash mix multipliers and the lattice offset applied to y
  localparam word_t MIX_K1   = 32'h7feb352d;
  localparam word_t MIX_K2   = 32'h846ca68b;
  localparam word_t Y_OFFSET = 32'h517cc1b7;

  // One in Q0.24 (25 bits) and three in Q0.24 (26 bits)
  localparam logic [Q_BITS:0]   ONE_Q   = (Q_BITS+1)'(1) << Q_BITS;
  localparam logic [Q_BITS+1:0] THREE_Q = (Q_BITS+2)'(3) << Q_BITS;

  // Seed value after reset
  localparam word_t SEED_RESET = 32'h0000_0001;

endpackage

@@ rtl/hvn_mix32.sv @@
// Two-stage pipelined 32-bit xor-shift and multiply hash mixer.
`timescale 1ns / 1ps

module hvn_mix32 (
  input  logic          clk,
  input  hvn_pkg::word_t w_in,
  output hvn_pkg::word_t h_out
);

  hvn_pkg::word_t w1;
  hvn_pkg::word_t w2;
  hvn_pkg::word_t p1_r;
  hvn_pkg::word_t p2_r;

  // First round: fold the high half down, multiply mod 2^32
  assign w1 = w_in ^ (w_in >> 16);

  always_ff @(posedge clk) begin
    p1_r <= 32'(w1 * hvn_pkg::MIX_K1);
  end

  // Second round
  assign w2 = p1_r ^ (p1_r >> 15);

  always_ff @(posedge clk) begin
    p2_r <= 32'(w2 * hvn_pkg::MIX_K2);
  end

  // Final fold after the last product register
  assign h_out = p2_r ^ (p2_r >> 16);

endmodule

@@ rtl/hvn_ease.sv @@
// Two-stage smoothstep 3t^2 - 2t^3 on a Q0.24 fraction, floor rounding.
`timescale 1ns / 1ps

module hvn_ease (
  input  logic         clk,
  input  hvn_pkg::q24_t t_in,
  output hvn_pkg::q24_t s_out
);

  logic [2*hvn_pkg::Q_BITS-1:0] tt;
  logic [hvn_pkg::Q_BITS+1:0]   k;
  hvn_pkg::q24_t                q_r;
  hvn_pkg::q24_t                t_d_r;
  logic [2*hvn_pkg::Q_BITS+1:0] prod_r;

  // Square the fraction, keep the top half
  assign tt = (2*hvn_pkg::Q_BITS)'(t_in) * (2*hvn_pkg::Q_BITS)'(t_in);

  always_ff @(posedge clk) begin
    q_r   <= tt[2*hvn_pkg::Q_BITS-1:hvn_pkg::Q_BITS];
    t_d_r <= t_in;
  end

  // Multiply by (3 - 2t); the result stays below one
  assign k = hvn_pkg::THREE_Q - {1'b0, t_d_r, 1'b0};

  always_ff @(posedge clk) begin
    prod_r <= (2*hvn_pkg::Q_BITS+2)'(q_r) * (2*hvn_pkg::Q_BITS+2)'(k);
  end

  assign s_out = prod_r[2*hvn_pkg::Q_BITS-1:hvn_pkg::Q_BITS];

endmodule

@@ rtl/hvn_blend.sv @@
// Two-stage linear blend a*(1-s) + b*s in Q0.24, floor rounding, registered out.
`timescale 1ns / 1ps

module hvn_blend (
  input  logic         clk,
  input  hvn_pkg::q24_t a_in,
  input  hvn_pkg::q24_t b_in,
  input  hvn_pkg::q24_t s_in,
  output hvn_pkg::q24_t y_out
);

  logic [hvn_pkg::Q_BITS:0]     w;
  logic [2*hvn_pkg::Q_BITS:0]   pa_r;
  logic [2*hvn_pkg::Q_BITS-1:0] pb_r;
  logic [2*hvn_pkg::Q_BITS:0]   sum;
  hvn_pkg::q24_t                y_r;

  // Weight of the first value
  assign w = hvn_pkg::ONE_Q - {1'b0, s_in};

  // Register both weighted products
  always_ff @(posedge clk) begin
    pa_r <= (2*hvn_pkg::Q_BITS+1)'(a_in) * (2*hvn_pkg::Q_BITS+1)'(w);
    pb_r <= (2*hvn_pkg::Q_BITS)'(b_in) * (2*hvn_pkg::Q_BITS)'(s_in);
  end

  // Add and drop the fraction; the sum never reaches 2^48
  assign sum = pa_r + (2*hvn_pkg::Q_BITS+1)'(pb_r);

  always_ff @(posedge clk) begin
    y_r <= sum[2*hvn_pkg::Q_BITS-1:hvn_pkg::Q_BITS];
  end

  assign y_out = y_r;

endmodule

@@ rtl/hashed_value_noise_2d.sv @@
// Top level of the hashed 2D value noise pipeline.
`timescale 1ns / 1ps

// Hashed 2D value noise: one coordinate pair (signed, FRAC_BITS fraction bits)
// in, one Q0.24 noise value out. A request is taken at every clock edge where
// start is high and busy is low; busy is high while reset is held and in the
// first cycle after it, so a new request may follow in every cycle. Each result
// appears on out_noise_value with out_strobe high for one cycle, in request
// order; its path runs through the input register, the two chained hash mixers
// (two multiplier stages each) and the two blend levels (product and sum stages
// each). cfg_ready is always high; write the seed only while no request is in
// flight.
module hashed_value_noise_2d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_x_coord,
  input  logic [31:0] in_y_coord,
  output logic        out_strobe,
  output logic [23:0] out_noise_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic                          accept;
  logic                          busy_r;
  hvn_pkg::word_t                seed_r;
  hvn_pkg::word_t                seed_nxt;
  logic [hvn_pkg::LATENCY:1]     valid_r;
  logic [hvn_pkg::LATENCY:1]     valid_nxt;
  hvn_pkg::word_t                x_r;
  hvn_pkg::word_t                y_r;
  hvn_pkg::word_t                ix;
  hvn_pkg::word_t                iy;
  hvn_pkg::q24_t                 tx;
  hvn_pkg::q24_t                 ty;
  hvn_pkg::word_t                lat_in [4];
  hvn_pkg::word_t                lat_h  [4];
  hvn_pkg::word_t                crn_in [4];
  hvn_pkg::word_t                crn_h  [4];
  hvn_pkg::q24_t                 u3;
  hvn_pkg::q24_t                 v3;
  hvn_pkg::q24_t                 u_r    [4:5];
  hvn_pkg::q24_t                 v_r    [4:7];
  hvn_pkg::q24_t                 row0;
  hvn_pkg::q24_t                 row1;

  // Handshake: config always ready, requests held off only during and just after reset
  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Seed register
  assign seed_nxt = (cfg_valid && cfg_ready) ? cfg_data : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= hvn_pkg::SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  // Advance the valid bits alongside the data
  assign valid_nxt = {valid_r[hvn_pkg::LATENCY-1:1], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the request coordinates
  always_ff @(posedge clk) begin
    x_r <= in_x_coord;
    y_r <= in_y_coord;
  end

  // Split into floor integer and widened fraction
  assign ix = 32'($signed(x_r) >>> hvn_pkg::FRAC_BITS);
  assign iy = 32'($signed(y_r) >>> hvn_pkg::FRAC_BITS);
  assign tx = hvn_pkg::Q_BITS'(x_r[hvn_pkg::FRAC_BITS-1:0])
              << (hvn_pkg::Q_BITS - hvn_pkg::FRAC_BITS);
  assign ty = hvn_pkg::Q_BITS'(y_r[hvn_pkg::FRAC_BITS-1:0])
              << (hvn_pkg::Q_BITS - hvn_pkg::FRAC_BITS);

  // Lattice hashes: x, x+1, and the offset y, y+1
  assign lat_in[0] = ix;
  assign lat_in[1] = ix + 32'd1;
  assign lat_in[2] = iy + hvn_pkg::Y_OFFSET;
  assign lat_in[3] = iy + 32'd1 + hvn_pkg::Y_OFFSET;

  // Corner hash inputs: (x,y), (x+1,y), (x,y+1), (x+1,y+1)
  assign crn_in[0] = seed_r ^ lat_h[0] ^ lat_h[2];
  assign crn_in[1] = seed_r ^ lat_h[1] ^ lat_h[2];
  assign crn_in[2] = seed_r ^ lat_h[0] ^ lat_h[3];
  assign crn_in[3] = seed_r ^ lat_h[1] ^ lat_h[3];

  for (genvar g = 0; g < 4; g++) begin : g_hash
    hvn_mix32 u_lat (
      .clk   (clk),
      .w_in  (lat_in[g]),
      .h_out (lat_h[g])
    );

    hvn_mix32 u_crn (
      .clk   (clk),
      .w_in  (crn_in[g]),
      .h_out (crn_h[g])
    );
  end

  // Ease both fractions
  hvn_ease u_ease_x (
    .clk   (clk),
    .t_in  (tx),
    .s_out (u3)
  );

  hvn_ease u_ease_y (
    .clk   (clk),
    .t_in  (ty),
    .s_out (v3)
  );

  // Delay the eased fractions to meet their blend levels
  always_ff @(posedge clk) begin
    u_r[4] <= u3;
    u_r[5] <= u_r[4];
    v_r[4] <= v3;
    v_r[5] <= v_r[4];
    v_r[6] <= v_r[5];
    v_r[7] <= v_r[6];
  end

  // Blend along x for both rows, using the top 24 bits of each corner hash
  hvn_blend u_row0 (
    .clk   (clk),
    .a_in  (crn_h[0][31:8]),
    .b_in  (crn_h[1][31:8]),
    .s_in  (u_r[5]),
    .y_out (row0)
  );

  hvn_blend u_row1 (
    .clk   (clk),
    .a_in  (crn_h[2][31:8]),
    .b_in  (crn_h[3][31:8]),
    .s_in  (u_r[5]),
    .y_out (row1)
  );

  // Blend along y into the output register
  hvn_blend u_col (
    .clk   (clk),
    .a_in  (row0),
    .b_in  (row1),
    .s_in  (v_r[7]),
    .y_out (out_noise_value)
  );

  assign out_strobe = valid_r[hvn_pkg::LATENCY];

`ifndef SYNTHESIS
  // Every accepted request yields its strobe after the fixed latency
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##9 out_strobe)
    else $error("accepted request produced no result strobe");

  // No strobe without a request the same latency earlier
  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 9))
    else $error("result strobe without a matching request");

  // Requests are refused only in the first cycle after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !$past(rst_n))
    else $error("busy raised outside the reset recovery cycle");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the hashed 2D value noise pipeline.
`timescale 1ns / 1ps

module testbench;

  typedef hvn_pkg::word_t word_t;
  typedef hvn_pkg::q24_t  q24_t;

  typedef struct packed {
    word_t x;
    word_t y;
  } coord_pair_t;

  typedef struct packed {
    word_t x;
    word_t y;
    q24_t  noise;
  } noise_expect_t;

  localparam word_t FRAC_MASK = word_t'((64'(1) << hvn_pkg::FRAC_BITS) - 1);
  localparam word_t ONE_INT   = word_t'(1) << hvn_pkg::FRAC_BITS;
  localparam word_t HALF_FRAC = word_t'(1) << (hvn_pkg::FRAC_BITS - 1);
  localparam int    RAND_PER_SEED = 80;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_x_coord = '0;
  logic [31:0] in_y_coord = '0;
  logic        out_strobe;
  logic [23:0] out_noise_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  coord_pair_t   pending_coords[$];
  noise_expect_t noise_expected[$];
  coord_pair_t   next_pair;
  noise_expect_t got_expect;
  word_t         seed_model = hvn_pkg::SEED_RESET;
  bit            req_taken = 1'b0;
  bit            no_idle = 1'b0;
  int            gap_left = 0;
  int            n_queued = 0;
  int            n_accepted = 0;
  int            n_checked = 0;
  int            n_errors = 0;
  int            n_seeds = 1;

  hashed_value_noise_2d dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .out_strobe      (out_strobe),
    .out_noise_value (out_noise_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Xor-shift and multiply scramble of one lattice word
  function automatic word_t scramble(word_t w);
    w = w ^ (w >> 16);
    w = w * hvn_pkg::MIX_K1;
    w = w ^ (w >> 15);
    w = w * hvn_pkg::MIX_K2;
    return w ^ (w >> 16);
  endfunction

  // Smoothstep easing of the fraction, widened to Q0.24
  function automatic logic [63:0] eased_frac(word_t c);
    logic [63:0] t;
    logic [63:0] q;
    t = 64'(c[hvn_pkg::FRAC_BITS-1:0]) << (hvn_pkg::Q_BITS - hvn_pkg::FRAC_BITS);
    q = (t * t) >> hvn_pkg::Q_BITS;
    return (q * ((64'(3) << hvn_pkg::Q_BITS) - 2 * t)) >> hvn_pkg::Q_BITS;
  endfunction

  function automatic logic [63:0] lattice_value(word_t seed, word_t i, word_t j);
    return 64'(scramble(seed ^ scramble(i) ^ scramble(j + hvn_pkg::Y_OFFSET)) >> 8);
  endfunction

  function automatic logic [63:0] mix_q24(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] s);
    return (a * ((64'(1) << hvn_pkg::Q_BITS) - s) + b * s) >> hvn_pkg::Q_BITS;
  endfunction

  function automatic q24_t predict_noise(word_t seed, word_t xc, word_t yc);
    word_t       ix;
    word_t       iy;
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] row0;
    logic [63:0] row1;
    ix   = word_t'($signed(xc) >>> hvn_pkg::FRAC_BITS);
    iy   = word_t'($signed(yc) >>> hvn_pkg::FRAC_BITS);
    u    = eased_frac(xc);
    v    = eased_frac(yc);
    row0 = mix_q24(lattice_value(seed, ix, iy), lattice_value(seed, ix + 1, iy), u);
    row1 = mix_q24(lattice_value(seed, ix, iy + 1),
                   lattice_value(seed, ix + 1, iy + 1), u);
    return q24_t'(mix_q24(row0, row1, v));
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Random coordinate: full range, near the origin, or on a fraction edge
  function automatic word_t random_coord();
    int    k;
    word_t edge_frac;
    k = $urandom_range(0, 15);
    k = k - 8;
    case ($urandom_range(0, 3))
      0, 1: return word_t'($urandom());
      2: return (word_t'(k) << hvn_pkg::FRAC_BITS) | (word_t'($urandom()) & FRAC_MASK);
      default: begin
        case ($urandom_range(0, 3))
          0: edge_frac = '0;
          1: edge_frac = word_t'(1);
          2: edge_frac = FRAC_MASK - 1;
          default: edge_frac = FRAC_MASK;
        endcase
        return (word_t'($urandom()) & ~FRAC_MASK) | edge_frac;
      end
    endcase
  endfunction

  // Driver: present queued requests, holding each until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // hold the current request
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_coords.size() > 0) begin
      next_pair = pending_coords.pop_front();
      in_x_coord <= next_pair.x;
      in_y_coord <= next_pair.y;
      start <= 1'b1;
      gap_left = no_idle ? 0 : idle_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: track the seed, predict each taken request, check each result
  always @(posedge clk) begin
    req_taken = rst_n && start && !busy;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) seed_model = cfg_data;
      if (req_taken) begin
        noise_expected.insert(noise_expected.size(),
          noise_expect_t'{in_x_coord, in_y_coord,
                          predict_noise(seed_model, in_x_coord, in_y_coord)});
        n_accepted = n_accepted + 1;
      end
      if (out_strobe) begin
        if (noise_expected.size() == 0) begin
          $display("%0t: unexpected result %06h, nothing outstanding", $time,
                   out_noise_value);
          n_errors = n_errors + 1;
        end else begin
          got_expect = noise_expected.pop_front();
          n_checked = n_checked + 1;
          if (out_noise_value !== got_expect.noise) begin
            $display("%0t: noise mismatch x=%08h y=%08h: expected %06h, got %06h",
                     $time, got_expect.x, got_expect.y, got_expect.noise,
                     out_noise_value);
            n_errors = n_errors + 1;
          end
        end
      end
    end
  end

  task automatic enqueue(word_t xc, word_t yc);
    pending_coords.insert(pending_coords.size(), coord_pair_t'{xc, yc});
    n_queued = n_queued + 1;
  endtask

  // Wait until every request has been taken and its result checked
  task automatic wait_idle();
    do @(negedge clk);
    while (n_accepted != n_queued || n_checked != n_accepted);
  endtask

  task automatic write_seed(word_t seed);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= seed;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_seeds = n_seeds + 1;
  endtask

  // Coordinate extremes, lattice edges and fraction edges
  task automatic push_directed();
    enqueue(32'h0000_0000, 32'h0000_0000);
    enqueue(32'h7fff_ffff, 32'h7fff_ffff);
    enqueue(32'h8000_0000, 32'h8000_0000);
    enqueue(32'h8000_0000, 32'h7fff_ffff);
    enqueue(32'h7fff_ffff, 32'h8000_0000);
    enqueue(32'hffff_ffff, 32'hffff_ffff);
    enqueue(FRAC_MASK, 32'h0000_0000);
    enqueue(32'h0000_0000, FRAC_MASK);
    enqueue(32'h0000_0001, 32'h0000_0001);
    enqueue(HALF_FRAC, HALF_FRAC);
    enqueue(ONE_INT, ONE_INT);
    enqueue(-ONE_INT, -ONE_INT);
    enqueue(-HALF_FRAC, ONE_INT + HALF_FRAC);
    enqueue(32'h7fff_ffff & ~FRAC_MASK, 32'h8000_0000 | FRAC_MASK);
  endtask

  initial begin
    word_t seeds[5];
    seeds[0] = 32'h0000_0000;
    seeds[1] = 32'hffff_ffff;
    seeds[2] = word_t'($urandom());
    seeds[3] = 32'h8000_0000;
    seeds[4] = word_t'($urandom());

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests under the seed left by reset
    push_directed();
    wait_idle();

    // Random requests under each seed, extremes first for the first two seeds
    for (int p = 0; p < 5; p++) begin
      write_seed(seeds[p]);
      no_idle = (p == 2);
      if (p < 2) push_directed();
      for (int n = 0; n < RAND_PER_SEED; n++) enqueue(random_coord(), random_coord());
      wait_idle();
    end

    // Catch any stray result and any result that never arrived
    repeat (2 * hvn_pkg::LATENCY) @(negedge clk);
    if (noise_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, noise_expected.size());
      n_errors = n_errors + 1;
    end
    $display("Covered %0d coordinate requests under %0d seed settings,", n_accepted,
             n_seeds);
    $display("%0d results compared, %0d failures.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Guard against a hung pipeline
  initial begin
    #2_000_000;
    $display("%0t: timed out", $time);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hvn_pkg.sv
rtl/hvn_mix32.sv
rtl/hvn_ease.sv
rtl/hvn_blend.sv
rtl/hashed_value_noise_2d.sv
tb/testbench.sv
